// ----- design/ngps_pkg.sv -----
package ngps_pkg;

   // Store geometry
   localparam int MAX_ELEMENTS = 64;
   localparam int GRID_POINTS  = 5;
   localparam int PTS_PER_ELEM = GRID_POINTS * GRID_POINTS * GRID_POINTS;
   localparam int STORE_DEPTH  = MAX_ELEMENTS * PTS_PER_ELEM;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);

   // Field widths
   localparam int ELEM_W  = 6;
   localparam int GRID_W  = 3;
   localparam int COORD_W = 24;
   localparam int SQ_W    = 2 * COORD_W;
   localparam int DIST_W  = 50;
   localparam int CSR_W   = 7;
   localparam int POINT_W = 3 * COORD_W;

   localparam logic [GRID_W-1:0] GRID_LAST = GRID_W'(GRID_POINTS - 1);
   localparam logic [ELEM_W-1:0] ELEM_LAST = ELEM_W'(MAX_ELEMENTS - 1);

   // Operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [GRID_W-1:0] grid_k;
      logic [GRID_W-1:0] grid_j;
      logic [GRID_W-1:0] grid_i;
   } idx_type;

   typedef struct packed {
      logic [ELEM_W-1:0]         element;
      logic [GRID_W-1:0]         grid_k;
      logic [GRID_W-1:0]         grid_j;
      logic [GRID_W-1:0]         grid_i;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
   } req_data_type;

   typedef struct packed {
      idx_type           best_idx;
      logic [DIST_W-1:0] best_dist_sq;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic store_wr;
      logic query_start;
      logic issue;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_issue;
      logic pipe_busy;
      logic rsp_free;
   } sts_type;

endpackage

// ----- design/ngps_ifs.sv -----
interface ngps_req_if;
   import ngps_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      op;
   logic [ELEM_W-1:0]         element;
   logic [GRID_W-1:0]         grid_k;
   logic [GRID_W-1:0]         grid_j;
   logic [GRID_W-1:0]         grid_i;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;

   modport source (output valid, op, element, grid_k, grid_j, grid_i, pos_x, pos_y, pos_z,
                   input ready);
   modport sink   (input valid, op, element, grid_k, grid_j, grid_i, pos_x, pos_y, pos_z,
                   output ready);
endinterface

interface ngps_rsp_if;
   import ngps_pkg::*;

   logic              valid;
   logic              ready;
   logic [ELEM_W-1:0] best_element;
   logic [GRID_W-1:0] best_k;
   logic [GRID_W-1:0] best_j;
   logic [GRID_W-1:0] best_i;
   logic [DIST_W-1:0] best_dist_sq;

   modport source (output valid, best_element, best_k, best_j, best_i, best_dist_sq,
                   input ready);
   modport sink   (input valid, best_element, best_k, best_j, best_i, best_dist_sq,
                   output ready);
endinterface

// ----- design/nearest_grid_point_search.sv -----
// Brute-force nearest grid point search over a store of 64 elements x 5x5x5 points.
// A write transfer (op 0) stores one point; writes with a grid index
// of 5 or more are dropped. A query transfer (op 1) scans every point of the first
// elements_in_use elements (0 counts as 1, above 64 as 64) in element, k, j, i order and
// returns the nearest point and its squared distance, ties going to the first point met.
// A query occupies the block from its transfer to the earliest next transfer: the point
// store has one read port and gives one point per cycle, the four-stage distance pipeline
// (read, difference, square, sum) drains after the last read, and the controller then
// detects the drain, loads the result register and returns to idle. The next transfer is
// taken once the result is loaded, even while that result still waits on the response
// channel; a query that ends while the previous result is still unclaimed holds until the
// response channel takes it.
// Points must be written before any query scans them; the store is not cleared by reset.
module nearest_grid_point_search (
   input  logic       clock,
   input  logic       reset,
   ngps_req_if.sink   req_ch,
   ngps_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);
   import ngps_pkg::*;

   cmd_type      cmd;
   sts_type      sts;
   req_data_type req_data;
   rsp_data_type rsp_data;
   logic         req_ready;
   logic         rsp_valid;

   assign req_data.element = req_ch.element;
   assign req_data.grid_k  = req_ch.grid_k;
   assign req_data.grid_j  = req_ch.grid_j;
   assign req_data.grid_i  = req_ch.grid_i;
   assign req_data.pos_x   = req_ch.pos_x;
   assign req_data.pos_y   = req_ch.pos_y;
   assign req_data.pos_z   = req_ch.pos_z;
   assign req_ch.ready     = req_ready;

   assign rsp_ch.valid        = rsp_valid;
   assign rsp_ch.best_element = rsp_data.best_idx.element;
   assign rsp_ch.best_k       = rsp_data.best_idx.grid_k;
   assign rsp_ch.best_j       = rsp_data.best_idx.grid_j;
   assign rsp_ch.best_i       = rsp_data.best_idx.grid_i;
   assign rsp_ch.best_dist_sq = rsp_data.best_dist_sq;

   ngps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.op),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ngps_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .sts         (sts)
   );

endmodule

// ----- design/ngps_ctrl.sv -----
module ngps_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_op,
   output logic              req_ready,
   input  ngps_pkg::sts_type sts,
   output ngps_pkg::cmd_type cmd
);
   import ngps_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       req_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_QUERY) begin
                  cmd.query_start = 1'b1;
                  state_in        = ST_SCAN;
               end else begin
                  cmd.store_wr = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            if (sts.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the result register to be free
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/ngps_datapath.sv -----
module ngps_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ngps_pkg::cmd_type      cmd,
   input  ngps_pkg::req_data_type req_data,
   input  logic                   csr_wr_en,
   input  logic [6:0]             csr_wr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output ngps_pkg::rsp_data_type rsp_data,
   output ngps_pkg::sts_type      sts
);
   import ngps_pkg::*;

   // Point store: {x, y, z} per entry
   logic [POINT_W-1:0] store_mem [STORE_DEPTH];

   logic [CSR_W-1:0]          elem_count_ff;
   logic [ELEM_W-1:0]         last_elem_in;
   logic [ELEM_W-1:0]         last_elem_ff;
   logic signed [COORD_W-1:0] tx_ff, ty_ff, tz_ff;

   // Scan position
   idx_type           scan_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              last_issue;

   // Pipeline stages
   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   idx_type            s1_idx_ff, s2_idx_ff, s3_idx_ff, s4_idx_ff;
   logic [POINT_W-1:0] rd_data_ff;
   logic [COORD_W-1:0] ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic [DIST_W-1:0]  sum_ff;

   // Running best
   logic              have_ff;
   logic [DIST_W-1:0] best_d_ff;
   idx_type           best_idx_ff;

   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;

   logic              wr_ok;
   logic [ADDR_W-1:0] wr_addr;

   logic signed [COORD_W:0] dx, dy, dz;
   logic signed [COORD_W:0] mx, my, mz;

   // Write address and range check
   assign wr_ok = ({1'b0, req_data.element} < (ELEM_W + 1)'(MAX_ELEMENTS)) &&
                  (req_data.grid_k < GRID_W'(GRID_POINTS)) &&
                  (req_data.grid_j < GRID_W'(GRID_POINTS)) &&
                  (req_data.grid_i < GRID_W'(GRID_POINTS));
   assign wr_addr = ADDR_W'(req_data.element) * ADDR_W'(PTS_PER_ELEM) +
                    ADDR_W'(req_data.grid_k) * ADDR_W'(GRID_POINTS * GRID_POINTS) +
                    ADDR_W'(req_data.grid_j) * ADDR_W'(GRID_POINTS) +
                    ADDR_W'(req_data.grid_i);

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store_wr && wr_ok) begin
         store_mem[wr_addr] <= {req_data.pos_x, req_data.pos_y, req_data.pos_z};
      end
      if (cmd.issue) begin
         rd_data_ff <= store_mem[addr_ff];
      end
   end

   // Element count clamped to 1..MAX_ELEMENTS
   always_comb begin
      if (elem_count_ff == '0) begin
         last_elem_in = '0;
      end else if (elem_count_ff > CSR_W'(MAX_ELEMENTS)) begin
         last_elem_in = ELEM_LAST;
      end else begin
         last_elem_in = ELEM_W'(elem_count_ff - 1'b1);
      end
   end

   assign last_issue = (scan_ff.element == last_elem_ff) && (scan_ff.grid_k == GRID_LAST) &&
                       (scan_ff.grid_j == GRID_LAST) && (scan_ff.grid_i == GRID_LAST);

   // Config register and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         elem_count_ff <= CSR_W'(1);
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         have_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            elem_count_ff <= csr_wr_data;
         end
         s1_valid_ff <= cmd.issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         if (cmd.query_start) begin
            have_ff <= 1'b0;
         end else if (s4_valid_ff) begin
            have_ff <= 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Query setup and scan counters
   always_ff @(posedge clock) begin
      if (cmd.query_start) begin
         tx_ff        <= req_data.pos_x;
         ty_ff        <= req_data.pos_y;
         tz_ff        <= req_data.pos_z;
         last_elem_ff <= last_elem_in;
         scan_ff      <= '0;
         addr_ff      <= '0;
      end else if (cmd.issue) begin
         addr_ff <= addr_ff + 1'b1;
         if (scan_ff.grid_i != GRID_LAST) begin
            scan_ff.grid_i <= scan_ff.grid_i + 1'b1;
         end else begin
            scan_ff.grid_i <= '0;
            if (scan_ff.grid_j != GRID_LAST) begin
               scan_ff.grid_j <= scan_ff.grid_j + 1'b1;
            end else begin
               scan_ff.grid_j <= '0;
               if (scan_ff.grid_k != GRID_LAST) begin
                  scan_ff.grid_k <= scan_ff.grid_k + 1'b1;
               end else begin
                  scan_ff.grid_k  <= '0;
                  scan_ff.element <= scan_ff.element + 1'b1;
               end
            end
         end
      end
   end

   // Absolute differences
   assign dx = {tx_ff[COORD_W-1], tx_ff} -
               {rd_data_ff[POINT_W-1], rd_data_ff[POINT_W-1 -: COORD_W]};
   assign dy = {ty_ff[COORD_W-1], ty_ff} -
               {rd_data_ff[2*COORD_W-1], rd_data_ff[2*COORD_W-1 -: COORD_W]};
   assign dz = {tz_ff[COORD_W-1], tz_ff} -
               {rd_data_ff[COORD_W-1], rd_data_ff[COORD_W-1:0]};
   assign mx = dx[COORD_W] ? -dx : dx;
   assign my = dy[COORD_W] ? -dy : dy;
   assign mz = dz[COORD_W] ? -dz : dz;

   // Distance pipeline: diff, square, sum
   always_ff @(posedge clock) begin
      s1_idx_ff <= scan_ff;
      s2_idx_ff <= s1_idx_ff;
      s3_idx_ff <= s2_idx_ff;
      s4_idx_ff <= s3_idx_ff;
      ax_ff     <= mx[COORD_W-1:0];
      ay_ff     <= my[COORD_W-1:0];
      az_ff     <= mz[COORD_W-1:0];
      sqx_ff    <= ax_ff * ax_ff;
      sqy_ff    <= ay_ff * ay_ff;
      sqz_ff    <= az_ff * az_ff;
      sum_ff    <= DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);
   end

   // Keep the first strictly smaller distance
   always_ff @(posedge clock) begin
      if (s4_valid_ff && (!have_ff || (sum_ff < best_d_ff))) begin
         best_d_ff   <= sum_ff;
         best_idx_ff <= s4_idx_ff;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.best_idx     <= best_idx_ff;
         rsp_data_ff.best_dist_sq <= best_d_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;
   assign sts.last_issue = last_issue;
   assign sts.pipe_busy  = s1_valid_ff || s2_valid_ff || s3_valid_ff || s4_valid_ff;
   assign sts.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule
